### rtl/acd_pkg.sv
// Package for the audio clock divider select block.
// Holds widths, clock constants, status codes, sequencer types and the family lookup.
// No dependencies; every other file imports it.
package acd_pkg;

	localparam int RATE_W = 18;
	localparam int CLK_W = 27;
	localparam int ACH_W = 19;
	localparam int PRE_W = 5;
	localparam int STAT_W = 2;

	// Largest legal divider, and the width that holds it.
	localparam int MAX_DIVIDER = 32;
	localparam int DIV_W = $clog2(MAX_DIVIDER + 1);

	// Divider operand widths: numerator is clock plus half the divisor.
	localparam int NUM_W = CLK_W + 1;
	localparam int DEN_W = CLK_W;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [CLK_W-1:0] CLK_8K = CLK_W'(32769231);
	localparam logic [CLK_W-1:0] CLK_11K = CLK_W'(67714286);
	localparam logic [CLK_W-1:0] CLK_12K = CLK_W'(73714286);

	localparam logic [ACH_W-1:0] RATE_MIN = ACH_W'(4000);
	localparam logic [ACH_W-1:0] RATE_MAX = ACH_W'(100000);

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_BIG   = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_FINISH
	} seq_state_t;

	// The four divisions, in the order they run.
	typedef enum logic [1:0] {
		PH_DIV256,
		PH_DIV384,
		PH_REAL256,
		PH_REAL384
	} phase_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	// Choose the PLL clock for a rate family; other rates keep the current clock.
	function automatic logic [CLK_W-1:0] pick_clock(
		input logic [RATE_W-1:0] rate,
		input logic [CLK_W-1:0]  cur
	);
		logic [CLK_W-1:0] res;
		case (rate)
			RATE_W'(8000), RATE_W'(16000), RATE_W'(32000): res = CLK_8K;
			RATE_W'(11025), RATE_W'(22050), RATE_W'(44100): res = CLK_11K;
			RATE_W'(12000), RATE_W'(24000), RATE_W'(48000): res = CLK_12K;
			default: res = cur;
		endcase
		return res;
	endfunction

endpackage

### rtl/acd_req_if.sv
// Request channel: one requested sample rate per item.
// Depends on acd_pkg for the field width.
interface acd_req_if import acd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] requested_rate;

	modport source (output valid, output requested_rate, input ready);
	modport sink (input valid, input requested_rate, output ready);
endinterface

### rtl/acd_rsp_if.sv
// Result channel: status, frame choice, prescaler, achieved rate and clock per item.
// Depends on acd_pkg for the field widths.
interface acd_rsp_if import acd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              frame_is_384;
	logic [PRE_W-1:0]  prescaler;
	logic [ACH_W-1:0]  achieved_rate;
	logic [CLK_W-1:0]  clock_rate;

	modport source (
		output valid, output status, output frame_is_384, output prescaler,
		output achieved_rate, output clock_rate, input ready
	);
	modport sink (
		input valid, input status, input frame_is_384, input prescaler,
		input achieved_rate, input clock_rate, output ready
	);
endinterface

### rtl/acd_div.sv
// Shared restoring divider: one quotient bit per cycle, NUM_W quotient bits per division.
// Depends on acd_pkg for operand widths and the request/response structs.
module acd_div import acd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [NUM_W-1:0] shifted;
	logic [NUM_W:0]   diff;
	logic             ge;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff = {1'b0, shifted} - {2'b0, den_q};
		ge = ~diff[NUM_W];
	end

	// Control: count the iterations and flag the cycle after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: the numerator shifts out of quo_q while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

### rtl/audio_clock_divider_select.sv
// Takes one requested sample rate per item and returns one result item. The PLL
// clock is chosen by rate family and held as state, then up to four rounded divisions
// run one after another on a single shared bit-serial divider: the 256fs and 384fs
// dividers and the rates each produces. Each division goes through issue, 28 quotient
// bits and completion. A zero request skips the divisions, and a divider fault ends the
// item after the first two. A result is offered in the same cycle as the request side
// becomes ready again. The request side is not ready while an item is being worked on;
// a finished result waits in an output register until it is taken.
// Depends on acd_pkg, acd_req_if, acd_rsp_if and acd_div.
module audio_clock_divider_select import acd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	acd_req_if.sink   req,
	acd_rsp_if.source rsp
);

	seq_state_t state_q, state_d;
	phase_t     phase_q, phase_d;

	logic [RATE_W-1:0] rate_q;
	logic [CLK_W-1:0]  clk_q;
	logic [DIV_W-1:0]  div1_q, div2_q;
	logic [ACH_W-1:0]  real1_q, real2_q;
	logic              div1_zero_q, div1_big_q;
	status_t           status_q;

	logic              ovalid_q;
	status_t           ostatus_q;
	logic              oframe_q;
	logic [PRE_W-1:0]  opre_q;
	logic [ACH_W-1:0]  oach_q;
	logic [CLK_W-1:0]  oclk_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              accept;
	logic              load_out;
	logic              take_quo;
	logic              set_status;
	status_t           status_d;

	logic [RATE_W-1:0] factor;
	logic [DIV_W-1:0]  div_sel;
	logic [DEN_W-1:0]  den256, den384;
	logic              phase_384;
	logic              q_zero, q_big;

	logic              range_bad;
	logic [ACH_W-1:0]  err1, err2;
	logic              pick_384;
	status_t           res_status;
	logic              res_frame;
	logic [PRE_W-1:0]  res_pre;
	logic [ACH_W-1:0]  res_ach;
	logic [DIV_W-1:0]  div_pick;

	acd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Divisor and rounded numerator for the current phase.
	always_comb begin
		phase_384 = (phase_q == PH_DIV384) || (phase_q == PH_REAL384);
		div_sel = (phase_q == PH_REAL256) ? div1_q : div2_q;
		factor = ((phase_q == PH_DIV256) || (phase_q == PH_DIV384)) ?
			rate_q : RATE_W'(div_sel);
		den256 = {1'b0, factor, 8'b0};
		den384 = den256 + {2'b0, factor, 7'b0};
		div_req.den = phase_384 ? den384 : den256;
		div_req.num = {1'b0, clk_q} + {2'b0, div_req.den[DEN_W-1:1]};
		div_req.start = (state_q == S_ISSUE);
		q_zero = (div_rsp.quo == '0);
		q_big = (div_rsp.quo > NUM_W'(MAX_DIVIDER));
	end

	// Range check and frame choice once all four divisions are in.
	always_comb begin
		range_bad = (real1_q < RATE_MIN) || (real1_q > RATE_MAX) ||
			(real2_q < RATE_MIN) || (real2_q > RATE_MAX);
		err1 = ({1'b0, rate_q} >= real1_q) ? {1'b0, rate_q} - real1_q :
			real1_q - {1'b0, rate_q};
		err2 = ({1'b0, rate_q} >= real2_q) ? {1'b0, rate_q} - real2_q :
			real2_q - {1'b0, rate_q};
		pick_384 = (err1 > err2);
		div_pick = pick_384 ? div2_q : div1_q;
		res_status = status_q;
		res_frame = 1'b0;
		res_pre = '0;
		res_ach = '0;
		if (status_q == ST_OK) begin
			if (range_bad) begin
				res_status = ST_RANGE;
			end else begin
				res_frame = pick_384;
				res_pre = PRE_W'(div_pick - 1'b1);
				res_ach = pick_384 ? real2_q : real1_q;
			end
		end
	end

	// Sequencer: next state and control strobes.
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		accept = 1'b0;
		load_out = 1'b0;
		take_quo = 1'b0;
		set_status = 1'b0;
		status_d = ST_OK;
		req.ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					accept = 1'b1;
					set_status = 1'b1;
					phase_d = PH_DIV256;
					if (req.requested_rate == '0) begin
						status_d = ST_ZERO;
						state_d = S_FINISH;
					end else begin
						state_d = S_ISSUE;
					end
				end
			end
			S_ISSUE: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (div_rsp.done) begin
					take_quo = 1'b1;
					state_d = S_ISSUE;
					unique case (phase_q)
						PH_DIV256: phase_d = PH_DIV384;
						PH_DIV384: begin
							phase_d = PH_REAL256;
							if (div1_zero_q || q_zero) begin
								set_status = 1'b1;
								status_d = ST_ZERO;
								state_d = S_FINISH;
							end else if (div1_big_q || q_big) begin
								set_status = 1'b1;
								status_d = ST_BIG;
								state_d = S_FINISH;
							end
						end
						PH_REAL256: phase_d = PH_REAL384;
						PH_REAL384: state_d = S_FINISH;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FINISH: begin
				if (!ovalid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state, the held PLL clock and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_DIV256;
			clk_q <= CLK_8K;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (accept) begin
				clk_q <= pick_clock(req.requested_rate, clk_q);
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Working registers for the request and the division results.
	always_ff @(posedge clk) begin
		if (accept) begin
			rate_q <= req.requested_rate;
		end
		if (set_status) begin
			status_q <= status_d;
		end
		if (take_quo) begin
			unique case (phase_q)
				PH_DIV256: begin
					div1_q <= div_rsp.quo[DIV_W-1:0];
					div1_zero_q <= q_zero;
					div1_big_q <= q_big;
				end
				PH_DIV384: div2_q <= div_rsp.quo[DIV_W-1:0];
				PH_REAL256: real1_q <= div_rsp.quo[ACH_W-1:0];
				PH_REAL384: real2_q <= div_rsp.quo[ACH_W-1:0];
				default: ;
			endcase
		end
		if (load_out) begin
			ostatus_q <= res_status;
			oframe_q <= res_frame;
			opre_q <= res_pre;
			oach_q <= res_ach;
			oclk_q <= clk_q;
		end
	end

	assign rsp.valid = ovalid_q;
	assign rsp.status = ostatus_q;
	assign rsp.frame_is_384 = oframe_q;
	assign rsp.prescaler = opre_q;
	assign rsp.achieved_rate = oach_q;
	assign rsp.clock_rate = oclk_q;

endmodule

### rtl/acd_checker.sv
// Port-level checks for audio_clock_divider_select, attached by the bind below.
// Depends on acd_pkg for widths, status codes and clock constants.
module acd_checker import acd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] rsp_status,
	input logic              rsp_frame_is_384,
	input logic [PRE_W-1:0]  rsp_prescaler,
	input logic [ACH_W-1:0]  rsp_achieved_rate,
	input logic [CLK_W-1:0]  rsp_clock_rate
);

	// A result that is waiting stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while an item is in flight");

	// Failed requests carry no divider, frame or rate.
	a_error_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |->
			(rsp_prescaler == '0) && (rsp_achieved_rate == '0) && !rsp_frame_is_384)
		else $error("error result carries nonzero fields");

	// A good result lies in the legal rate range.
	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_OK) |->
			(rsp_achieved_rate >= RATE_MIN) && (rsp_achieved_rate <= RATE_MAX))
		else $error("good result outside the rate range");

	// The reported clock is always one of the three PLL settings.
	a_clock_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp_clock_rate == CLK_8K) || (rsp_clock_rate == CLK_11K) ||
			(rsp_clock_rate == CLK_12K))
		else $error("unknown PLL clock reported");

endmodule

bind audio_clock_divider_select acd_checker u_acd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_frame_is_384  (rsp.frame_is_384),
	.rsp_prescaler     (rsp.prescaler),
	.rsp_achieved_rate (rsp.achieved_rate),
	.rsp_clock_rate    (rsp.clock_rate)
);

### tb/audio_clock_divider_select_test.sv
// Self-checking testbench for audio_clock_divider_select: drives requested sample rates,
// predicts each result with its own model of the PLL family choice and divider search.
// Depends on acd_pkg, acd_req_if, acd_rsp_if and the block itself.
module audio_clock_divider_select_test;
	timeunit 1ns;
	timeprecision 1ps;

	import acd_pkg::*;

	localparam int FRAME_SHORT = 256;
	localparam int FRAME_LONG = 384;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_RATES = 1430;
	localparam int BACKLOG_HOLD = 600;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		status_t               status;
		logic                  frame_is_384;
		logic [PRE_W-1:0]      prescaler;
		logic [ACH_W-1:0]      achieved_rate;
		logic [CLK_W-1:0]      clock_rate;
	} divider_choice_t;

	// Holds the predicted divider choices in order and checks the block against them.
	class divider_choice_book;
		logic [CLK_W-1:0] pll_clock;
		divider_choice_t  pending_choices[$];
		int               mismatches;

		function new();
			pll_clock = CLK_8K;
			mismatches = 0;
		endfunction

		function longint unsigned round_quotient(longint unsigned num, longint unsigned den);
			return (num + den / 2) / den;
		endfunction

		// Family clock update, then the two divider candidates and their achieved rates.
		function divider_choice_t predict_choice(logic [RATE_W-1:0] rate);
			divider_choice_t res;
			longint unsigned clk_hz, rate_hz, div_a, div_b, real_a, real_b, err_a, err_b;
			case (rate)
				RATE_W'(8000), RATE_W'(16000), RATE_W'(32000): pll_clock = CLK_8K;
				RATE_W'(11025), RATE_W'(22050), RATE_W'(44100): pll_clock = CLK_11K;
				RATE_W'(12000), RATE_W'(24000), RATE_W'(48000): pll_clock = CLK_12K;
				default: ;
			endcase
			res.status = ST_OK;
			res.frame_is_384 = 1'b0;
			res.prescaler = '0;
			res.achieved_rate = '0;
			res.clock_rate = pll_clock;
			if (rate == '0) begin
				res.status = ST_ZERO;
				return res;
			end
			clk_hz = pll_clock;
			rate_hz = rate;
			div_a = round_quotient(clk_hz, FRAME_SHORT * rate_hz);
			div_b = round_quotient(clk_hz, FRAME_LONG * rate_hz);
			if (div_a == 0 || div_b == 0) begin
				res.status = ST_ZERO;
				return res;
			end
			if (div_a > MAX_DIVIDER || div_b > MAX_DIVIDER) begin
				res.status = ST_BIG;
				return res;
			end
			real_a = round_quotient(clk_hz, FRAME_SHORT * div_a);
			real_b = round_quotient(clk_hz, FRAME_LONG * div_b);
			if (real_a < RATE_MIN || real_a > RATE_MAX || real_b < RATE_MIN
					|| real_b > RATE_MAX) begin
				res.status = ST_RANGE;
				return res;
			end
			err_a = (rate_hz >= real_a) ? rate_hz - real_a : real_a - rate_hz;
			err_b = (rate_hz >= real_b) ? rate_hz - real_b : real_b - rate_hz;
			// Equal errors keep the 256fs frame.
			if (err_a <= err_b) begin
				res.prescaler = PRE_W'(div_a - 1);
				res.achieved_rate = ACH_W'(real_a);
			end else begin
				res.frame_is_384 = 1'b1;
				res.prescaler = PRE_W'(div_b - 1);
				res.achieved_rate = ACH_W'(real_b);
			end
			return res;
		endfunction

		function void note_request(logic [RATE_W-1:0] rate);
			pending_choices.push_back(predict_choice(rate));
		endfunction

		function void check_result(divider_choice_t got);
			divider_choice_t want;
			if (pending_choices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: %p", $realtime, got);
				return;
			end
			want = pending_choices.pop_front();
			if (got.status !== want.status || got.frame_is_384 !== want.frame_is_384
					|| got.prescaler !== want.prescaler
					|| got.achieved_rate !== want.achieved_rate
					|| got.clock_rate !== want.clock_rate) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected status=%0d frame384=%0d pre=%0d rate=%0d clk=%0d",
						want.status, want.frame_is_384, want.prescaler,
						want.achieved_rate, want.clock_rate);
					$display("  actual   status=%0d frame384=%0d pre=%0d rate=%0d clk=%0d",
						got.status, got.frame_is_384, got.prescaler,
						got.achieved_rate, got.clock_rate);
				end
			end
		endfunction

		function int pending();
			return pending_choices.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	acd_req_if req_ch ();
	acd_rsp_if rsp_ch ();

	audio_clock_divider_select u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	divider_choice_book book;
	int  accepted_rates = 0;
	int  idle_cycles = 0;
	bit  steady_flow = 1'b0;
	bit  backlog_done = 1'b0;
	bit  reset_done = 1'b0;

	always #5 clk = ~clk;

	// Random gap length: mostly none or short, a few long.
	function automatic int pick_gap(int long_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 30);
		return $urandom_range(100, long_max);
	endfunction

	// Random rate: family rates and near them, useful band, fault edges, full range.
	function automatic logic [RATE_W-1:0] pick_rate();
		int r;
		int family [9] = '{8000, 16000, 32000, 11025, 22050, 44100, 12000, 24000, 48000};
		r = $urandom_range(0, 99);
		if (r < 30)
			return RATE_W'(family[$urandom_range(0, 8)]);
		if (r < 62)
			return RATE_W'($urandom_range(4000, 110000));
		if (r < 74)
			return RATE_W'($urandom_range(0, 262143));
		if (r < 84)
			return RATE_W'($urandom_range(100000, 180000));
		if (r < 91)
			return RATE_W'($urandom_range(0, 4200));
		return RATE_W'(family[$urandom_range(0, 8)] + $urandom_range(0, 3));
	endfunction

	// Offers one rate after a gap and holds it until the block takes it.
	task automatic send_rate(input logic [RATE_W-1:0] rate, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : pick_gap(200);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.requested_rate <= rate;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Result side: random stalls, one long hold to back the block up, none while steady.
	initial begin
		int hold;
		rsp_ch.ready <= 1'b0;
		wait (reset_done);
		forever begin
			hold = steady_flow ? 0 : pick_gap(300);
			if (!backlog_done && accepted_rates >= 300) begin
				hold = BACKLOG_HOLD;
				backlog_done = 1'b1;
			end
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Handshake monitor: predicts on each accepted request, checks each accepted result.
	always @(posedge clk) begin
		divider_choice_t seen;
		if (reset_done) begin
			if (req_ch.valid && req_ch.ready) begin
				book.note_request(req_ch.requested_rate);
				accepted_rates++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.status = status_t'(rsp_ch.status);
				seen.frame_is_384 = rsp_ch.frame_is_384;
				seen.prescaler = rsp_ch.prescaler;
				seen.achieved_rate = rsp_ch.achieved_rate;
				seen.clock_rate = rsp_ch.clock_rate;
				book.check_result(seen);
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Reset, directed rates, random rates, then drain and report.
	initial begin
		int directed [] = '{0, 1, 262143, 8000, 200000, 4000, 3999, 2000, 11025, 100000,
			12000, 150000, 96000, 16000, 22050, 24000, 32000, 44100, 48000, 8001,
			131071, 170000, 65535};
		book = new();
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.requested_rate <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reset_done = 1'b1;

		foreach (directed[i])
			send_rate(RATE_W'(directed[i]), 1'b0);

		for (int n = 0; n < RANDOM_RATES; n++) begin
			steady_flow = (n >= 700 && n < 900);
			send_rate(pick_rate(), steady_flow);
		end
		steady_flow = 1'b0;
		req_ch.valid <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (book.mismatches == 0 && book.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
